/* rtl/gzhp_pkg.sv */
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared types, codes and helpers for the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

	// header flag bits
	localparam logic [7:0] FL_CONT    = 8'h02;
	localparam logic [7:0] FL_EXTRA   = 8'h04;
	localparam logic [7:0] FL_NAME    = 8'h08;
	localparam logic [7:0] FL_COMMENT = 8'h10;
	localparam logic [7:0] FL_CRYPT   = 8'h20;
	localparam logic [7:0] FL_RESV    = 8'hC0;
	localparam logic [7:0] FL_BAD     = FL_CRYPT | FL_CONT | FL_RESV;

	// magic and method bytes
	localparam logic [7:0] MAGIC_ID1     = 8'h1F;
	localparam logic [7:0] MAGIC_ID2     = 8'h8B;
	localparam logic [7:0] MAGIC_ID2_OLD = 8'h9E;
	localparam logic [7:0] METHOD_DEFL   = 8'h08;

	// saturation limits
	localparam int unsigned TOTAL_W   = 20;
	localparam int unsigned MEMBERS_W = 16;
	localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;
	localparam logic [MEMBERS_W-1:0] MEMBERS_MAX = '1;

	// parse phase
	typedef enum logic [4:0] {
		PH_MAGIC0  = 5'd0,
		PH_MAGIC1  = 5'd1,
		PH_METHOD  = 5'd2,
		PH_FLAGS   = 5'd3,
		PH_TIME0   = 5'd4,
		PH_TIME1   = 5'd5,
		PH_TIME2   = 5'd6,
		PH_TIME3   = 5'd7,
		PH_XFL     = 5'd8,
		PH_OS      = 5'd9,
		PH_XLEN0   = 5'd10,
		PH_XLEN1   = 5'd11,
		PH_XDATA   = 5'd12,
		PH_NAME    = 5'd13,
		PH_COMMENT = 5'd14,
		PH_PAYLOAD = 5'd15,
		PH_ERROR   = 5'd16
	} phase_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_HEADER  = 3'd0,
		ST_DONE    = 3'd1,
		ST_PAYLOAD = 3'd2,
		ST_MAGIC   = 3'd3,
		ST_METHOD  = 3'd4,
		ST_FLAGS   = 3'd5,
		ST_HELD    = 3'd6
	} status_t;

	// input request payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	// result payload
	typedef struct packed {
		logic [2:0]           status;
		logic                 name_valid;
		logic [7:0]           name_byte;
		logic [31:0]          mod_time;
		logic [TOTAL_W-1:0]   header_length;
		logic [MEMBERS_W-1:0] member_count;
	} out_item_t;

	// next optional section after the one ending at flag bit 'from'
	function automatic phase_t next_section(logic [7:0] flags, logic [7:0] from);
		phase_t ph;
		ph = PH_PAYLOAD;
		if (from < FL_COMMENT && (flags & FL_COMMENT) != 8'h00) ph = PH_COMMENT;
		if (from < FL_NAME && (flags & FL_NAME) != 8'h00)       ph = PH_NAME;
		if (from < FL_EXTRA && (flags & FL_EXTRA) != 8'h00)     ph = PH_XLEN0;
		return ph;
	endfunction

endpackage

/* rtl/gzhp_stream_if.sv */
// ----------------------------------------------------------------------------
// gzhp_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface gzhp_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/gzhp_in_stage.sv */
// ----------------------------------------------------------------------------
// gzhp_in_stage
// Input register: holds one accepted request until the parser takes it.
// ----------------------------------------------------------------------------
module gzhp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  gzhp_pkg::in_item_t in_data,
	output logic              in_ready,
	input  logic              take,
	output logic              valid_s1,
	output gzhp_pkg::in_item_t item_s1
);
	// accept when empty or draining this cycle
	assign in_ready = !valid_s1 || take;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end
endmodule

/* rtl/gzhp_core.sv */
// ----------------------------------------------------------------------------
// gzhp_core
// Header phase machine and field registers; one byte per step.
// ----------------------------------------------------------------------------
module gzhp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  gzhp_pkg::in_item_t  item,
	output gzhp_pkg::out_item_t result
);
	gzhp_pkg::phase_t                      phase_q, ph_eff, ph_d;
	logic [7:0]                            first_magic_q, fm_eff, fm_d;
	logic [7:0]                            flags_q, flags_eff, flags_d;
	logic [31:0]                           time_q, time_eff, time_d;
	logic [15:0]                           skip_q, skip_eff, skip_d;
	logic [gzhp_pkg::TOTAL_W-1:0]          total_q, total_eff, total_d;
	logic [gzhp_pkg::MEMBERS_W-1:0]        members_q, members_d;
	logic [7:0]                            b;
	logic                                  in_header;
	gzhp_pkg::status_t                     status;
	logic                                  name_valid;
	logic [7:0]                            name_byte;

	assign b = item.data_byte;

	// restart clears the header state before the byte is parsed
	always_comb begin
		if (item.restart) begin
			ph_eff    = gzhp_pkg::PH_MAGIC0;
			fm_eff    = '0;
			flags_eff = '0;
			time_eff  = '0;
			skip_eff  = '0;
			total_eff = '0;
		end else begin
			ph_eff    = phase_q;
			fm_eff    = first_magic_q;
			flags_eff = flags_q;
			time_eff  = time_q;
			skip_eff  = skip_q;
			total_eff = total_q;
		end
	end

	assign in_header = ph_eff < gzhp_pkg::PH_PAYLOAD;

	// next phase
	always_comb begin
		ph_d = ph_eff;
		unique case (ph_eff) inside
			gzhp_pkg::PH_MAGIC0: ph_d = gzhp_pkg::PH_MAGIC1;
			gzhp_pkg::PH_MAGIC1: begin
				if (fm_eff == gzhp_pkg::MAGIC_ID1 &&
				    (b == gzhp_pkg::MAGIC_ID2 || b == gzhp_pkg::MAGIC_ID2_OLD))
					ph_d = gzhp_pkg::PH_METHOD;
				else
					ph_d = gzhp_pkg::PH_ERROR;
			end
			gzhp_pkg::PH_METHOD: begin
				ph_d = (b == gzhp_pkg::METHOD_DEFL) ? gzhp_pkg::PH_FLAGS : gzhp_pkg::PH_ERROR;
			end
			gzhp_pkg::PH_FLAGS: begin
				ph_d = ((b & gzhp_pkg::FL_BAD) != 8'h00) ? gzhp_pkg::PH_ERROR
				                                         : gzhp_pkg::PH_TIME0;
			end
			gzhp_pkg::PH_TIME0, gzhp_pkg::PH_TIME1, gzhp_pkg::PH_TIME2: begin
				ph_d = gzhp_pkg::phase_t'(ph_eff + 5'd1);
			end
			gzhp_pkg::PH_TIME3: ph_d = gzhp_pkg::PH_XFL;
			gzhp_pkg::PH_XFL:   ph_d = gzhp_pkg::PH_OS;
			gzhp_pkg::PH_OS:    ph_d = gzhp_pkg::next_section(flags_eff, 8'h00);
			gzhp_pkg::PH_XLEN0: ph_d = gzhp_pkg::PH_XLEN1;
			gzhp_pkg::PH_XLEN1: begin
				ph_d = ({b, skip_eff[7:0]} == 16'h0000)
				     ? gzhp_pkg::next_section(flags_eff, gzhp_pkg::FL_EXTRA)
				     : gzhp_pkg::PH_XDATA;
			end
			gzhp_pkg::PH_XDATA: begin
				if (skip_eff == 16'h0001)
					ph_d = gzhp_pkg::next_section(flags_eff, gzhp_pkg::FL_EXTRA);
			end
			gzhp_pkg::PH_NAME: begin
				if (b == 8'h00) ph_d = gzhp_pkg::next_section(flags_eff, gzhp_pkg::FL_NAME);
			end
			gzhp_pkg::PH_COMMENT: begin
				if (b == 8'h00) ph_d = gzhp_pkg::PH_PAYLOAD;
			end
			gzhp_pkg::PH_PAYLOAD: ph_d = gzhp_pkg::PH_PAYLOAD;
			gzhp_pkg::PH_ERROR:   ph_d = gzhp_pkg::PH_ERROR;
			default:              ph_d = gzhp_pkg::PH_ERROR;
		endcase
	end

	// field updates and result outputs
	always_comb begin
		fm_d       = fm_eff;
		flags_d    = flags_eff;
		time_d     = time_eff;
		skip_d     = skip_eff;
		total_d    = total_eff;
		members_d  = members_q;
		name_valid = 1'b0;
		name_byte  = 8'h00;
		status     = gzhp_pkg::ST_HEADER;

		if (in_header && total_eff != gzhp_pkg::TOTAL_MAX)
			total_d = total_eff + 1'b1;

		case (ph_eff)
			gzhp_pkg::PH_MAGIC0: begin
				fm_d = b;
				if (members_q != gzhp_pkg::MEMBERS_MAX) members_d = members_q + 1'b1;
			end
			gzhp_pkg::PH_FLAGS:  flags_d = b;
			gzhp_pkg::PH_TIME0:  time_d[7:0]   = time_eff[7:0] | b;
			gzhp_pkg::PH_TIME1:  time_d[15:8]  = time_eff[15:8] | b;
			gzhp_pkg::PH_TIME2:  time_d[23:16] = time_eff[23:16] | b;
			gzhp_pkg::PH_TIME3:  time_d[31:24] = time_eff[31:24] | b;
			gzhp_pkg::PH_XLEN0:  skip_d = {8'h00, b};
			gzhp_pkg::PH_XLEN1:  skip_d = {b, skip_eff[7:0]};
			gzhp_pkg::PH_XDATA:  skip_d = skip_eff - 16'd1;
			gzhp_pkg::PH_NAME: begin
				if (b != 8'h00) begin
					name_valid = 1'b1;
					name_byte  = b;
				end
			end
			default: ;
		endcase

		// status of this byte
		if (ph_eff == gzhp_pkg::PH_PAYLOAD) begin
			status = gzhp_pkg::ST_PAYLOAD;
		end else if (!in_header) begin
			status = gzhp_pkg::ST_HELD;
		end else if (ph_d == gzhp_pkg::PH_PAYLOAD) begin
			status = gzhp_pkg::ST_DONE;
		end else if (ph_d == gzhp_pkg::PH_ERROR) begin
			case (ph_eff)
				gzhp_pkg::PH_MAGIC1: status = gzhp_pkg::ST_MAGIC;
				gzhp_pkg::PH_METHOD: status = gzhp_pkg::ST_METHOD;
				default:             status = gzhp_pkg::ST_FLAGS;
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= gzhp_pkg::PH_MAGIC0;
			first_magic_q <= '0;
			flags_q       <= '0;
			time_q        <= '0;
			skip_q        <= '0;
			total_q       <= '0;
			members_q     <= '0;
		end else if (step) begin
			phase_q       <= ph_d;
			first_magic_q <= fm_d;
			flags_q       <= flags_d;
			time_q        <= time_d;
			skip_q        <= skip_d;
			total_q       <= total_d;
			members_q     <= members_d;
		end
	end

	// result fields
	always_comb begin
		result.status        = status;
		result.name_valid    = name_valid;
		result.name_byte     = name_byte;
		result.mod_time      = time_d;
		result.header_length = total_d;
		result.member_count  = members_d;
	end
endmodule

/* rtl/gzhp_out_stage.sv */
// ----------------------------------------------------------------------------
// gzhp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module gzhp_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  gzhp_pkg::out_item_t result,
	output logic                free,
	output logic                out_valid,
	output gzhp_pkg::out_item_t out_data,
	input  logic                out_ready
);
	logic                valid_q;
	gzhp_pkg::out_item_t data_q;

	// slot can take a result when empty or being read now
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end
endmodule

/* rtl/gzip_member_header_parser.sv */
// ----------------------------------------------------------------------------
// gzip_member_header_parser
// Byte-at-a-time gzip member header parser with valid/ready channels.
// ----------------------------------------------------------------------------
// Each input request carries one stream byte and a restart mark; each byte
// yields exactly one result holding the parse status, an original-name byte
// when one is seen, the modification time gathered so far and saturating
// header-byte and member counts. A byte is taken every cycle while the
// result channel keeps up: it sits in an input register, the header phase
// machine processes it and the result lands in an output register.
// Throughput is one byte per clock unless the result channel stalls,
// limited only by the single phase-machine update per byte. Backpressure on the
// result channel stalls the input once both registers are full. Errors
// latch until a byte arrives with restart set.
module gzip_member_header_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	gzhp_stream_if.sink          hdr_in,
	gzhp_stream_if.source        hdr_out
);
	logic                valid_s1;
	gzhp_pkg::in_item_t  item_s1;
	gzhp_pkg::out_item_t result;
	logic                out_free;
	logic                step;

	// process the held byte whenever the result slot can take it
	assign step = valid_s1 && out_free;

	gzhp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (hdr_in.valid),
		.in_data  (hdr_in.data),
		.in_ready (hdr_in.ready),
		.take     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gzhp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	gzhp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.result    (result),
		.free      (out_free),
		.out_valid (hdr_out.valid),
		.out_data  (hdr_out.data),
		.out_ready (hdr_out.ready)
	);

	// a result that ends the header never carries a name byte
	a_done_no_name: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_out.valid && hdr_out.data.status == gzhp_pkg::ST_DONE)
		|-> !hdr_out.data.name_valid)
		else $error("header done result carries a name byte");

	// name bytes are nonzero and only appear inside a header
	a_name_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.name_valid)
		|-> (result.name_byte != 8'h00 && result.status == gzhp_pkg::ST_HEADER))
		else $error("name byte outside header or zero");

	// a byte that was processed shows up as a valid result next cycle
	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> hdr_out.valid)
		else $error("processed byte did not produce a result");

	// a payload or held byte result reaches the result register with its header length unchanged
	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (result.status == gzhp_pkg::ST_PAYLOAD || result.status == gzhp_pkg::ST_HELD))
		|=> (hdr_out.data.header_length == $past(result.header_length)))
		else $error("result register lost a processed result");
endmodule

/* dv/tb_gzip_member_header_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gzip_member_header_parser
// Self-checking bench for the gzip member header parser. A byte request
// queue feeds a driver, a bench-side copy of the header phase machine
// predicts the result of every accepted byte, and a monitor compares each
// result field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_gzip_member_header_parser;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_BYTES = 550;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PRINT_CAP    = 40;

	logic clk;
	logic arst_n;

	gzhp_stream_if #(.item_t(gzhp_pkg::in_item_t))  byte_ch ();
	gzhp_stream_if #(.item_t(gzhp_pkg::out_item_t)) result_ch ();

	gzip_member_header_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.hdr_in  (byte_ch),
		.hdr_out (result_ch)
	);

	// bench copy of the parse state
	gzhp_pkg::phase_t ph_q   = gzhp_pkg::PH_MAGIC0;
	logic [7:0]  magic_lo_q  = '0;
	logic [7:0]  flags_q     = '0;
	logic [31:0] mtime_q     = '0;
	logic [15:0] skip_q      = '0;
	logic [19:0] hdr_bytes_q = '0;
	logic [15:0] members_q   = '0;

	gzhp_pkg::in_item_t  byte_backlog[$];
	gzhp_pkg::out_item_t predicted_results[$];
	gzhp_pkg::out_item_t got;
	gzhp_pkg::out_item_t want;

	int unsigned bytes_total = 0;
	int unsigned bytes_taken = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_left    = 0;
	int unsigned calm_in     = 0;
	int unsigned stall_left  = 0;
	int unsigned calm_out    = 0;
	int unsigned stall_draw  = 0;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// optional section that follows the one closed by flag bit done_bit
	function automatic gzhp_pkg::phase_t section_after(input logic [7:0] done_bit);
		if (done_bit < gzhp_pkg::FL_EXTRA && (flags_q & gzhp_pkg::FL_EXTRA) != 8'h00)
			return gzhp_pkg::PH_XLEN0;
		if (done_bit < gzhp_pkg::FL_NAME && (flags_q & gzhp_pkg::FL_NAME) != 8'h00)
			return gzhp_pkg::PH_NAME;
		if (done_bit < gzhp_pkg::FL_COMMENT && (flags_q & gzhp_pkg::FL_COMMENT) != 8'h00)
			return gzhp_pkg::PH_COMMENT;
		return gzhp_pkg::PH_PAYLOAD;
	endfunction

	// advance the header phase machine by one byte and build its result
	function automatic gzhp_pkg::out_item_t parse_byte(input gzhp_pkg::in_item_t req);
		gzhp_pkg::out_item_t res;
		logic [7:0]          b;
		int unsigned         idx;
		b = req.data_byte;
		res = '0;
		res.status = gzhp_pkg::ST_HEADER;
		// restart drops the header and any held error
		if (req.restart) begin
			ph_q        = gzhp_pkg::PH_MAGIC0;
			magic_lo_q  = '0;
			flags_q     = '0;
			mtime_q     = '0;
			skip_q      = '0;
			hdr_bytes_q = '0;
		end
		if (ph_q == gzhp_pkg::PH_PAYLOAD) begin
			res.status = gzhp_pkg::ST_PAYLOAD;
		end else if (ph_q == gzhp_pkg::PH_ERROR) begin
			res.status = gzhp_pkg::ST_HELD;
		end else begin
			if (hdr_bytes_q != gzhp_pkg::TOTAL_MAX) hdr_bytes_q = hdr_bytes_q + 1'b1;
			case (ph_q)
				gzhp_pkg::PH_MAGIC0: begin
					if (members_q != gzhp_pkg::MEMBERS_MAX) members_q = members_q + 1'b1;
					magic_lo_q = b;
					ph_q = gzhp_pkg::PH_MAGIC1;
				end
				gzhp_pkg::PH_MAGIC1: begin
					if (magic_lo_q == gzhp_pkg::MAGIC_ID1 &&
					    (b == gzhp_pkg::MAGIC_ID2 || b == gzhp_pkg::MAGIC_ID2_OLD)) begin
						ph_q = gzhp_pkg::PH_METHOD;
					end else begin
						ph_q = gzhp_pkg::PH_ERROR;
						res.status = gzhp_pkg::ST_MAGIC;
					end
				end
				gzhp_pkg::PH_METHOD: begin
					if (b == gzhp_pkg::METHOD_DEFL) begin
						ph_q = gzhp_pkg::PH_FLAGS;
					end else begin
						ph_q = gzhp_pkg::PH_ERROR;
						res.status = gzhp_pkg::ST_METHOD;
					end
				end
				gzhp_pkg::PH_FLAGS: begin
					flags_q = b;
					if ((b & gzhp_pkg::FL_BAD) != 8'h00) begin
						ph_q = gzhp_pkg::PH_ERROR;
						res.status = gzhp_pkg::ST_FLAGS;
					end else begin
						ph_q = gzhp_pkg::PH_TIME0;
					end
				end
				gzhp_pkg::PH_TIME0, gzhp_pkg::PH_TIME1,
				gzhp_pkg::PH_TIME2, gzhp_pkg::PH_TIME3: begin
					idx = 32'(ph_q - gzhp_pkg::PH_TIME0);
					mtime_q = mtime_q | (32'(b) << (8 * idx));
					ph_q = (ph_q == gzhp_pkg::PH_TIME3) ? gzhp_pkg::PH_XFL
					                                    : gzhp_pkg::phase_t'(ph_q + 1'b1);
				end
				gzhp_pkg::PH_XFL: ph_q = gzhp_pkg::PH_OS;
				gzhp_pkg::PH_OS: ph_q = section_after(8'h00);
				gzhp_pkg::PH_XLEN0: begin
					skip_q = {8'h00, b};
					ph_q = gzhp_pkg::PH_XLEN1;
				end
				gzhp_pkg::PH_XLEN1: begin
					skip_q[15:8] = b;
					ph_q = (skip_q == 16'h0000) ? section_after(gzhp_pkg::FL_EXTRA)
					                            : gzhp_pkg::PH_XDATA;
				end
				gzhp_pkg::PH_XDATA: begin
					skip_q = skip_q - 1'b1;
					if (skip_q == 16'h0000) ph_q = section_after(gzhp_pkg::FL_EXTRA);
				end
				gzhp_pkg::PH_NAME: begin
					if (b == 8'h00) begin
						ph_q = section_after(gzhp_pkg::FL_NAME);
					end else begin
						res.name_valid = 1'b1;
						res.name_byte = b;
					end
				end
				gzhp_pkg::PH_COMMENT: begin
					if (b == 8'h00) ph_q = gzhp_pkg::PH_PAYLOAD;
				end
				default: ;
			endcase
			if (ph_q == gzhp_pkg::PH_PAYLOAD) res.status = gzhp_pkg::ST_DONE;
		end
		res.mod_time      = mtime_q;
		res.header_length = hdr_bytes_q;
		res.member_count  = members_q;
		return res;
	endfunction

	// idle length: mostly none, some short, a few long, with calm stretches
	function automatic int unsigned idle_pick(inout int unsigned calm, input int unsigned pct);
		int unsigned roll;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			calm = $urandom_range(40, 120);
			return 0;
		end
		if (roll >= pct + 2) return 0;
		if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, seen, wanted);
	endtask

	task automatic queue_byte(input logic [7:0] value, input logic mark);
		gzhp_pkg::in_item_t req;
		req.data_byte = value;
		req.restart   = mark;
		byte_backlog.push_back(req);
	endtask

	// byte request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.data  <= '0;
			gap_left      <= 0;
		end else if (!byte_ch.valid || byte_ch.ready) begin
			if (byte_backlog.size() != 0 && gap_left == 0) begin
				byte_ch.valid <= 1'b1;
				byte_ch.data  <= byte_backlog.pop_front();
				gap_left      <= idle_pick(calm_in, 30);
			end else begin
				byte_ch.valid <= 1'b0;
				if (gap_left != 0) gap_left <= gap_left - 1;
			end
		end
	end

	// result monitor, byte prediction and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left      <= 0;
		end else begin
			// compare the result against the oldest prediction
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (predicted_results.size() == 0) begin
					report_mismatch("result with none pending", 64'(got.status), 64'd0);
				end else begin
					want = predicted_results.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.name_valid !== want.name_valid)
						report_mismatch("name_valid", 64'(got.name_valid),
							64'(want.name_valid));
					if (got.name_byte !== want.name_byte)
						report_mismatch("name_byte", 64'(got.name_byte), 64'(want.name_byte));
					if (got.mod_time !== want.mod_time)
						report_mismatch("mod_time", 64'(got.mod_time), 64'(want.mod_time));
					if (got.header_length !== want.header_length)
						report_mismatch("header_length", 64'(got.header_length),
							64'(want.header_length));
					if (got.member_count !== want.member_count)
						report_mismatch("member_count", 64'(got.member_count),
							64'(want.member_count));
				end
			end
			// predict every accepted byte request
			if (byte_ch.valid && byte_ch.ready) begin
				predicted_results.push_back(parse_byte(byte_ch.data));
				bytes_taken++;
			end
			// receiver stalls
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left      <= stall_left - 1;
			end else begin
				stall_draw       = idle_pick(calm_out, 15);
				result_ch.ready <= (stall_draw == 0);
				stall_left      <= (stall_draw == 0) ? 0 : stall_draw - 1;
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		logic [7:0]  flags;
		logic [7:0]  bad;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [15:0] xlen;
		int unsigned cnt;
		bit          big;
		bit          big_done;
		big_done = 1'b0;
		arst_n = 1'b0;

		// first member with no restart mark, time all ones, payload extremes
		queue_byte(gzhp_pkg::MAGIC_ID1, 1'b0);
		queue_byte(gzhp_pkg::MAGIC_ID2, 1'b0);
		queue_byte(gzhp_pkg::METHOD_DEFL, 1'b0);
		queue_byte(8'h00, 1'b0);
		repeat (4) queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		// bad second magic byte, then a held byte
		queue_byte(gzhp_pkg::MAGIC_ID1, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(gzhp_pkg::MAGIC_ID2, 1'b0);
		// bad first magic byte
		queue_byte(8'h00, 1'b1);
		queue_byte(gzhp_pkg::MAGIC_ID2, 1'b0);
		// old magic form with a bad method
		queue_byte(gzhp_pkg::MAGIC_ID1, 1'b1);
		queue_byte(gzhp_pkg::MAGIC_ID2_OLD, 1'b0);
		queue_byte(gzhp_pkg::METHOD_DEFL - 8'd1, 1'b0);
		// every flag bit set
		queue_byte(gzhp_pkg::MAGIC_ID1, 1'b1);
		queue_byte(gzhp_pkg::MAGIC_ID2_OLD, 1'b0);
		queue_byte(gzhp_pkg::METHOD_DEFL, 1'b0);
		queue_byte(8'hFF, 1'b0);

		// random members: mostly well formed, the rest broken or noise
		while (byte_backlog.size() < 24 + RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 72) begin
				big = !big_done && byte_backlog.size() > 200;
				flags = 8'($urandom_range(0, 31)) & ~gzhp_pkg::FL_CONT;
				if (big) flags = flags | gzhp_pkg::FL_EXTRA;
				queue_byte(gzhp_pkg::MAGIC_ID1, 1'b1);
				queue_byte($urandom_range(0, 1) ? gzhp_pkg::MAGIC_ID2
				                                : gzhp_pkg::MAGIC_ID2_OLD, 1'b0);
				queue_byte(gzhp_pkg::METHOD_DEFL, 1'b0);
				queue_byte(flags, 1'b0);
				// time, extra flags and os
				repeat (6) queue_byte(8'($urandom), 1'b0);
				if ((flags & gzhp_pkg::FL_EXTRA) != 8'h00) begin
					if (big) begin
						big_done = 1'b1;
						xlen = 16'($urandom_range(256, 300));
					end else if ($urandom_range(0, 7) == 0) begin
						xlen = '0;
					end else begin
						xlen = 16'($urandom_range(1, 6));
					end
					queue_byte(xlen[7:0], 1'b0);
					queue_byte(xlen[15:8], 1'b0);
					repeat (xlen) queue_byte(8'($urandom), 1'b0);
				end
				if ((flags & gzhp_pkg::FL_NAME) != 8'h00) begin
					cnt = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 48)
							: $urandom_range(0, 5);
					repeat (cnt) queue_byte(8'($urandom_range(1, 255)), 1'b0);
					queue_byte(8'h00, 1'b0);
				end
				if ((flags & gzhp_pkg::FL_COMMENT) != 8'h00) begin
					repeat ($urandom_range(0, 4)) queue_byte(8'($urandom_range(1, 255)), 1'b0);
					queue_byte(8'h00, 1'b0);
				end
				repeat ($urandom_range(0, 6)) queue_byte(8'($urandom), 1'b0);
			end else begin
				case ($urandom_range(0, 4))
					0: begin
						// bad magic pair
						b1 = ($urandom_range(0, 1) == 0) ? gzhp_pkg::MAGIC_ID1 : 8'($urandom);
						do
							b2 = 8'($urandom);
						while (b1 == gzhp_pkg::MAGIC_ID1 &&
						       (b2 == gzhp_pkg::MAGIC_ID2 || b2 == gzhp_pkg::MAGIC_ID2_OLD));
						queue_byte(b1, 1'b1);
						queue_byte(b2, 1'b0);
					end
					1: begin
						// bad method
						do
							b1 = 8'($urandom);
						while (b1 == gzhp_pkg::METHOD_DEFL);
						queue_byte(gzhp_pkg::MAGIC_ID1, 1'b1);
						queue_byte($urandom_range(0, 1) ? gzhp_pkg::MAGIC_ID2
						                                : gzhp_pkg::MAGIC_ID2_OLD, 1'b0);
						queue_byte(b1, 1'b0);
					end
					2: begin
						// forbidden flag bits
						case ($urandom_range(0, 2))
							0: bad = gzhp_pkg::FL_CONT;
							1: bad = gzhp_pkg::FL_CRYPT;
							default: bad = gzhp_pkg::FL_RESV & 8'($urandom_range(1, 3) << 6);
						endcase
						queue_byte(gzhp_pkg::MAGIC_ID1, 1'b1);
						queue_byte($urandom_range(0, 1) ? gzhp_pkg::MAGIC_ID2
						                                : gzhp_pkg::MAGIC_ID2_OLD, 1'b0);
						queue_byte(gzhp_pkg::METHOD_DEFL, 1'b0);
						queue_byte(8'($urandom) | bad, 1'b0);
					end
					3: begin
						// header cut short by the next restart
						queue_byte(gzhp_pkg::MAGIC_ID1, 1'b1);
						queue_byte($urandom_range(0, 1) ? gzhp_pkg::MAGIC_ID2
						                                : gzhp_pkg::MAGIC_ID2_OLD, 1'b0);
						queue_byte(gzhp_pkg::METHOD_DEFL, 1'b0);
						queue_byte(8'($urandom_range(0, 31)) & ~gzhp_pkg::FL_CONT, 1'b0);
						repeat ($urandom_range(0, 9)) queue_byte(8'($urandom), 1'b0);
					end
					default: begin
						// raw noise with sparse restarts
						repeat ($urandom_range(1, 6))
							queue_byte(8'($urandom), $urandom_range(0, 5) == 0);
					end
				endcase
				repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0);
			end
		end
		bytes_total = byte_backlog.size();

		// reset, then wait for every request and result
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (bytes_taken < bytes_total) @(posedge clk);
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
